// File: rtl/oaid_pkg.sv
`default_nettype none

package oaid_pkg;

  localparam int DefaultDepth = 128;
  localparam int DataW        = 32;
  localparam int PosW         = 8;
  localparam int CountW       = 8;
  localparam int InDataW      = 40;
  localparam int OutDataW     = 40;

  typedef enum logic [0:0] {
    ReqInsert = 1'b0,
    ReqDelete = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ShIdle = 3'b001,
    ShRun  = 3'b010,
    ShFin  = 3'b100
  } shift_state_e;

  typedef struct packed {
    logic start;
    logic del;
  } shift_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } shift_stat_t;

endpackage

`default_nettype wire

// File: rtl/oaid_shift.sv
`default_nettype none

module oaid_shift #(
  parameter int DEPTH = oaid_pkg::DefaultDepth,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire oaid_pkg::shift_cmd_t       cmd_i,
  input  wire logic [AW-1:0]              lo_addr_i,
  input  wire logic [AW-1:0]              hi_addr_i,
  input  wire logic [CW-1:0]              moves_i,
  input  wire logic [oaid_pkg::DataW-1:0] value_i,
  output oaid_pkg::shift_stat_t           stat_o,
  output logic [oaid_pkg::DataW-1:0]      removed_o
);

  logic [oaid_pkg::DataW-1:0] mem [DEPTH];
  logic [oaid_pkg::DataW-1:0] rdata_q;

  oaid_pkg::shift_state_e state_q, state_d;
  logic [AW-1:0]              addr_q;
  logic [CW-1:0]              remain_q;
  logic                       del_q;
  logic                       first_q;
  logic                       rd_vld_q;
  logic [AW-1:0]              rd_addr_q;
  logic [AW-1:0]              ins_addr_q;
  logic [oaid_pkg::DataW-1:0] value_q;
  logic [oaid_pkg::DataW-1:0] removed_q;

  logic                       launch;
  logic                       we;
  logic [AW-1:0]              wa;
  logic [oaid_pkg::DataW-1:0] wd;

  assign launch = (state_q == oaid_pkg::ShRun) && (remain_q != '0);

  always_comb begin
    we = 1'b0;
    wa = rd_addr_q;
    wd = rdata_q;
    if (state_q == oaid_pkg::ShFin) begin
      we = !del_q;
      wa = ins_addr_q;
      wd = value_q;
    end else if (rd_vld_q) begin
      we = !(del_q && first_q);
      wa = del_q ? rd_addr_q - AW'(1) : rd_addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (launch) begin
      rdata_q <= mem[addr_q];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oaid_pkg::ShIdle: if (cmd_i.start) state_d = oaid_pkg::ShRun;
      oaid_pkg::ShRun:  if (remain_q == '0 && !rd_vld_q) state_d = oaid_pkg::ShFin;
      oaid_pkg::ShFin:  state_d = oaid_pkg::ShIdle;
      default:          state_d = oaid_pkg::ShIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= oaid_pkg::ShIdle;
      remain_q  <= '0;
      rd_vld_q  <= 1'b0;
      first_q   <= 1'b0;
      del_q     <= 1'b0;
      removed_q <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= launch;
      if (state_q == oaid_pkg::ShIdle && cmd_i.start) begin
        remain_q  <= moves_i;
        del_q     <= cmd_i.del;
        first_q   <= 1'b1;
        removed_q <= '0;
      end else begin
        if (launch) begin
          remain_q <= remain_q - CW'(1);
        end
        if (rd_vld_q) begin
          first_q <= 1'b0;
          if (del_q && first_q) begin
            removed_q <= rdata_q;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == oaid_pkg::ShIdle && cmd_i.start) begin
      addr_q     <= cmd_i.del ? lo_addr_i : hi_addr_i;
      ins_addr_q <= lo_addr_i;
      value_q    <= value_i;
    end else if (launch) begin
      addr_q <= del_q ? addr_q + AW'(1) : addr_q - AW'(1);
    end
    if (launch) begin
      rd_addr_q <= addr_q;
    end
  end

  assign stat_o.busy = (state_q != oaid_pkg::ShIdle);
  assign stat_o.done = (state_q == oaid_pkg::ShFin);
  assign removed_o   = removed_q;

endmodule

`default_nettype wire

// File: rtl/ordered_array_insert_delete.sv
// channel  dir  tdata (low bit up)                      tuser
// s_axis   in   position[7:0], item_value[39:8]         req_type (0 insert, 1 delete)
// m_axis   out  removed_value[31:0], list_count[39:32]  success
//
// One memory port pair moves one entry per cycle: a successful request reads
// count - position + 1 entries and shows its result once the shift engine
// finishes; a rejected one shows it the next cycle.
// One item is worked on at a time; the result register frees the input side
// as soon as the result is taken. Reset clears the count; list storage is
// not cleared. A stalled result holds until m_axis_tready_i.
`default_nettype none

module ordered_array_insert_delete #(
  parameter int DEPTH = oaid_pkg::DefaultDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [oaid_pkg::InDataW-1:0]  s_axis_tdata_i,  // position, item_value
  input  wire logic                          s_axis_tuser_i,  // req_type
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [oaid_pkg::OutDataW-1:0]      m_axis_tdata_o,  // removed_value, list_count
  output logic                               m_axis_tuser_o   // success
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > oaid_pkg::PosW) ? CW : oaid_pkg::PosW) + 1;

  logic [CW-1:0]  cnt_q, cnt_d;
  logic           out_vld_q;
  logic           out_ok_q;
  logic [oaid_pkg::DataW-1:0]  out_rem_q;
  logic [oaid_pkg::CountW-1:0] out_cnt_q;

  logic [PW-1:0]  pos_x;
  logic [PW-1:0]  cnt_x;
  logic           req_del;
  logic           req_ok;
  logic           accept;

  oaid_pkg::shift_cmd_t  cmd;
  oaid_pkg::shift_stat_t stat;
  logic [oaid_pkg::DataW-1:0] removed;

  assign pos_x   = PW'(s_axis_tdata_i[oaid_pkg::PosW-1:0]);
  assign cnt_x   = PW'(cnt_q);
  assign req_del = (s_axis_tuser_i == oaid_pkg::ReqDelete);
  assign req_ok  = req_del ? (pos_x != '0 && pos_x <= cnt_x)
                           : (pos_x != '0 && pos_x <= cnt_x + PW'(1) && cnt_x < PW'(DEPTH));

  assign s_axis_tready_o = !stat.busy && (!out_vld_q || m_axis_tready_i);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign cmd.start = accept && req_ok;
  assign cmd.del   = req_del;

  oaid_shift #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_shift (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .lo_addr_i (AW'(pos_x - PW'(1))),
    .hi_addr_i (AW'(cnt_x - PW'(1))),
    .moves_i   (CW'(cnt_x + PW'(1) - pos_x)),
    .value_i   (s_axis_tdata_i[oaid_pkg::PosW +: oaid_pkg::DataW]),
    .stat_o    (stat),
    .removed_o (removed)
  );

  logic del_q;

  always_comb begin
    cnt_d = cnt_q;
    if (stat.done) begin
      cnt_d = del_q ? cnt_q - CW'(1) : cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      del_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd.start) begin
        del_q <= req_del;
      end
      if (stat.done || (accept && !req_ok)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.done) begin
      out_ok_q  <= 1'b1;
      out_rem_q <= removed;
      out_cnt_q <= oaid_pkg::CountW'(cnt_d);
    end else if (accept && !req_ok) begin
      out_ok_q  <= 1'b0;
      out_rem_q <= '0;
      out_cnt_q <= oaid_pkg::CountW'(cnt_q);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_rem_q};

endmodule

`default_nettype wire

// File: rtl/oaid_checker.sv
`default_nettype none

module oaid_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [oaid_pkg::OutDataW-1:0] m_axis_tdata_o,
  input wire logic                          m_axis_tuser_o
);

  logic [oaid_pkg::CountW-1:0] last_cnt_q;
  logic [oaid_pkg::CountW-1:0] out_cnt;
  logic                        out_acc;

  assign out_cnt = m_axis_tdata_o[oaid_pkg::DataW +: oaid_pkg::CountW];
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= '0;
    end else if (out_acc) begin
      last_cnt_q <= out_cnt;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("item taken with a stalled result pending");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> m_axis_tvalid_o || !s_axis_tready_o)
    else $error("second item taken while one is in flight");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[oaid_pkg::DataW-1:0] == '0)
    else $error("rejected request returned a value");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (!m_axis_tuser_o && out_cnt == last_cnt_q) ||
                (m_axis_tuser_o && (out_cnt == last_cnt_q + oaid_pkg::CountW'(1) ||
                                    out_cnt == last_cnt_q - oaid_pkg::CountW'(1))))
    else $error("count moved by more than one entry");

endmodule

bind ordered_array_insert_delete oaid_checker u_oaid_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
